[rtl/adx_pkg.sv]
`timescale 1ns / 1ps
package adx_pkg;

  localparam int unsigned QueueDepth = 2;

  localparam logic [2:0] ST_NONE   = 3'd0;
  localparam logic [2:0] ST_TRUNC  = 3'd1;
  localparam logic [2:0] ST_RDPKRU = 3'd2;
  localparam logic [2:0] ST_WRPKRU = 3'd3;
  localparam logic [2:0] ST_ADCX   = 3'd4;
  localparam logic [2:0] ST_ADOX   = 3'd5;
  localparam logic [2:0] ST_ILLEGAL = 3'd6;

  localparam logic [2:0] OK_REG  = 3'd0;
  localparam logic [2:0] OK_BASE = 3'd1;
  localparam logic [2:0] OK_ABS  = 3'd2;
  localparam logic [2:0] OK_RIP  = 3'd3;
  localparam logic [2:0] OK_SIB  = 3'd4;

  localparam logic [4:0] NONE_REG = 5'd16;

  localparam logic [1:0] MAND_NONE = 2'd0;
  localparam logic [1:0] MAND_66   = 2'd1;
  localparam logic [1:0] MAND_F3   = 2'd2;

  typedef enum logic [8:0] {
    PH_PREFIX = 9'b000000001,
    PH_PK1    = 9'b000000010,
    PH_PK2    = 9'b000000100,
    PH_OPC0   = 9'b000001000,
    PH_OPC1   = 9'b000010000,
    PH_OPC2   = 9'b000100000,
    PH_MODRM  = 9'b001000000,
    PH_SIB    = 9'b010000000,
    PH_DISP   = 9'b100000000
  } phase_t;

  // classified instruction handed from front to back
  typedef struct packed {
    logic [2:0]  status;
    logic [3:0]  length;
    logic [3:0]  rex;
    logic [7:0]  modrm;
    logic [7:0]  sib;
    logic        a32;
    logic [31:0] disp;
    logic [2:0]  disp_bytes;
    logic [2:0]  segment;
  } dec_t;

  function automatic logic [2:0] segment_code(input logic [7:0] b);
    logic [2:0] s;
    case (b)
      8'h26: s = 3'd1;
      8'h2E: s = 3'd2;
      8'h36: s = 3'd3;
      8'h3E: s = 3'd4;
      8'h64: s = 3'd5;
      8'h65: s = 3'd6;
      default: s = 3'd0;
    endcase
    return s;
  endfunction

  function automatic logic [2:0] disp_size(input logic [7:0] modrm, input logic [2:0] sib_base);
    logic [2:0] n;
    case (modrm[7:6])
      2'd3: n = 3'd0;
      2'd1: n = 3'd1;
      2'd2: n = 3'd4;
      default: n = (modrm[2:0] == 3'd5 || (modrm[2:0] == 3'd4 && sib_base == 3'd5)) ?
                   3'd4 : 3'd0;
    endcase
    return n;
  endfunction

endpackage

[rtl/adx_front.sv]
`timescale 1ns / 1ps
module adx_front (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [7:0]         in_code_byte,
  input  logic               in_window_end,
  output logic               q_push,
  output adx_pkg::dec_t      q_data,
  input  logic               q_full
);

  adx_pkg::phase_t phase_r, phase_nxt;
  logic [3:0]  cnt_r, cnt_nxt;
  logic [2:0]  pfx_r, pfx_nxt;
  logic [1:0]  mand_r, mand_nxt;
  logic [2:0]  seg_r, seg_nxt;
  logic [3:0]  rex_r, rex_nxt;
  logic [7:0]  modrm_r, modrm_nxt;
  logic [7:0]  sib_r, sib_nxt;
  logic        a32_r, a32_nxt;
  logic [31:0] disp_r, disp_nxt;
  logic [2:0]  left_r, left_nxt;
  logic        skip_r, skip_nxt;

  logic        fire, emit, done;
  logic [2:0]  st;
  logic [3:0]  len;
  logic [2:0]  segc, dsz, pos;
  logic [7:0]  b;

  assign in_ready = !q_full;
  assign fire = in_valid && in_ready;
  assign b = in_code_byte;
  assign segc = adx_pkg::segment_code(b);

  always_comb begin
    phase_nxt = phase_r; cnt_nxt = cnt_r; pfx_nxt = pfx_r; mand_nxt = mand_r;
    seg_nxt = seg_r; rex_nxt = rex_r; modrm_nxt = modrm_r; sib_nxt = sib_r;
    a32_nxt = a32_r; disp_nxt = disp_r; left_nxt = left_r; skip_nxt = skip_r;
    done = 1'b0; emit = 1'b0; st = adx_pkg::ST_NONE; len = 4'd0;
    dsz = 3'd0; pos = 3'd0;
    if (!skip_r) begin
      case (phase_r)
        adx_pkg::PH_PREFIX: begin
          if (cnt_r == 4'd0 && b == 8'h0F) begin
            cnt_nxt = 4'd1; phase_nxt = adx_pkg::PH_PK1;
          end else if (pfx_r < 3'd5 && (b == 8'h66 || b == 8'hF3 || b == 8'h67 ||
                                        segc != 3'd0)) begin
            if (b == 8'h66 || b == 8'hF3) begin
              if (mand_r != adx_pkg::MAND_NONE &&
                  mand_r != ((b == 8'h66) ? adx_pkg::MAND_66 : adx_pkg::MAND_F3))
                done = 1'b1;
              mand_nxt = (b == 8'h66) ? adx_pkg::MAND_66 : adx_pkg::MAND_F3;
            end else if (b == 8'h67) begin
              a32_nxt = 1'b1;
            end else begin
              seg_nxt = segc;
            end
            pfx_nxt = pfx_r + 3'd1; cnt_nxt = cnt_r + 4'd1;
          end else if (b[7:4] == 4'h4) begin
            if (mand_r == adx_pkg::MAND_NONE) done = 1'b1;
            rex_nxt = b[3:0]; cnt_nxt = cnt_r + 4'd1; phase_nxt = adx_pkg::PH_OPC0;
          end else if (mand_r == adx_pkg::MAND_NONE) begin
            done = 1'b1;
          end else if (b != 8'h0F) begin
            done = 1'b1;
          end else begin
            cnt_nxt = cnt_r + 4'd1; phase_nxt = adx_pkg::PH_OPC1;
          end
        end
        adx_pkg::PH_PK1: begin
          if (b != 8'h01) done = 1'b1;
          cnt_nxt = 4'd2; phase_nxt = adx_pkg::PH_PK2;
        end
        adx_pkg::PH_PK2: begin
          done = 1'b1;
          if (b == 8'hEE) begin st = adx_pkg::ST_RDPKRU; len = 4'd3; end
          else if (b == 8'hEF) begin st = adx_pkg::ST_WRPKRU; len = 4'd3; end
        end
        adx_pkg::PH_OPC0: begin
          if (b != 8'h0F) done = 1'b1;
          cnt_nxt = cnt_r + 4'd1; phase_nxt = adx_pkg::PH_OPC1;
        end
        adx_pkg::PH_OPC1: begin
          if (b != 8'h38) done = 1'b1;
          cnt_nxt = cnt_r + 4'd1; phase_nxt = adx_pkg::PH_OPC2;
        end
        adx_pkg::PH_OPC2: begin
          if (b != 8'hF6) done = 1'b1;
          cnt_nxt = cnt_r + 4'd1; phase_nxt = adx_pkg::PH_MODRM;
        end
        adx_pkg::PH_MODRM: begin
          modrm_nxt = b; cnt_nxt = cnt_r + 4'd1;
          dsz = adx_pkg::disp_size(b, sib_r[2:0]);
          if (b[7:6] == 2'd3) begin
            done = 1'b1; st = adx_pkg::ST_ADCX; len = cnt_nxt;
          end else if (b[2:0] == 3'd4) begin
            phase_nxt = adx_pkg::PH_SIB;
          end else if (dsz == 3'd0) begin
            done = 1'b1; st = adx_pkg::ST_ADCX; len = cnt_nxt;
          end else begin
            left_nxt = dsz; phase_nxt = adx_pkg::PH_DISP;
          end
        end
        adx_pkg::PH_SIB: begin
          sib_nxt = b; cnt_nxt = cnt_r + 4'd1;
          dsz = adx_pkg::disp_size(modrm_r, b[2:0]);
          if (dsz == 3'd0) begin
            done = 1'b1; st = adx_pkg::ST_ADCX; len = cnt_nxt;
          end else begin
            left_nxt = dsz; phase_nxt = adx_pkg::PH_DISP;
          end
        end
        adx_pkg::PH_DISP: begin
          dsz = adx_pkg::disp_size(modrm_r, sib_r[2:0]);
          pos = dsz - left_r;
          case (pos[1:0])
            2'd0: disp_nxt[7:0] = b;
            2'd1: disp_nxt[15:8] = b;
            2'd2: disp_nxt[23:16] = b;
            default: disp_nxt[31:24] = b;
          endcase
          cnt_nxt = cnt_r + 4'd1; left_nxt = left_r - 3'd1;
          if (left_r == 3'd1) begin
            done = 1'b1; st = adx_pkg::ST_ADCX; len = cnt_nxt;
          end
        end
        default: done = 1'b1;
      endcase
      emit = done;
      if (!done && in_window_end) begin
        emit = 1'b1;
        if (phase_r == adx_pkg::PH_PREFIX && phase_nxt == adx_pkg::PH_PREFIX)
          st = (mand_nxt != adx_pkg::MAND_NONE) ? adx_pkg::ST_TRUNC : adx_pkg::ST_NONE;
        else if (phase_nxt == adx_pkg::PH_PK1)
          st = adx_pkg::ST_NONE;
        else
          st = adx_pkg::ST_TRUNC;
      end
    end
  end

  always_comb begin
    q_data = '0;
    q_data.status = st;
    q_data.length = len;
    q_data.rex = rex_nxt;
    q_data.modrm = modrm_nxt;
    q_data.sib = sib_nxt;
    q_data.a32 = a32_nxt;
    q_data.disp = disp_nxt;
    q_data.disp_bytes = adx_pkg::disp_size(modrm_nxt, sib_nxt[2:0]);
    q_data.segment = seg_nxt;
    if (st == adx_pkg::ST_ADCX && mand_nxt == adx_pkg::MAND_F3)
      q_data.status = adx_pkg::ST_ADOX;
  end

  assign q_push = fire && emit;

  always_ff @(posedge clk) begin
    if (!rst_n || (fire && in_window_end)) begin
      phase_r <= adx_pkg::PH_PREFIX;
      cnt_r <= '0; pfx_r <= '0; mand_r <= adx_pkg::MAND_NONE; seg_r <= '0;
      rex_r <= '0; modrm_r <= '0; sib_r <= '0; a32_r <= 1'b0; disp_r <= '0;
      left_r <= '0; skip_r <= 1'b0;
    end else if (fire) begin
      phase_r <= phase_nxt; cnt_r <= cnt_nxt; pfx_r <= pfx_nxt; mand_r <= mand_nxt;
      seg_r <= seg_nxt; rex_r <= rex_nxt; modrm_r <= modrm_nxt; sib_r <= sib_nxt;
      a32_r <= a32_nxt; disp_r <= disp_nxt; left_r <= left_nxt;
      skip_r <= skip_r | done;
    end
  end

`ifndef SYNTHESIS
  a_push_ready: assert property (@(posedge clk) disable iff (!rst_n)
    q_push |-> in_ready) else $error("push while queue full");
  a_skip_silent: assert property (@(posedge clk) disable iff (!rst_n)
    skip_r |-> !q_push) else $error("push while skipping");
  a_end_clears: assert property (@(posedge clk) disable iff (!rst_n)
    (fire && in_window_end) |=> (!skip_r && cnt_r == 4'd0))
    else $error("window end did not clear state");
`endif

endmodule

[rtl/adx_queue.sv]
`timescale 1ns / 1ps
module adx_queue #(
  parameter int unsigned DEPTH = adx_pkg::QueueDepth
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          push,
  input  adx_pkg::dec_t push_data,
  output logic          full,
  output logic          pop_valid,
  input  logic          pop,
  output adx_pkg::dec_t pop_data
);

  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  adx_pkg::dec_t mem_r [DEPTH];
  logic [AW-1:0] wp_r, rp_r;
  logic [AW:0]   cnt_r;

  assign full = (cnt_r == (AW+1)'(DEPTH));
  assign pop_valid = (cnt_r != '0);
  assign pop_data = mem_r[rp_r];

  always_ff @(posedge clk) begin
    if (push) mem_r[wp_r] <= push_data;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r <= '0; rp_r <= '0; cnt_r <= '0;
    end else begin
      if (push) wp_r <= (wp_r == AW'(DEPTH - 1)) ? '0 : wp_r + AW'(1);
      if (pop) rp_r <= (rp_r == AW'(DEPTH - 1)) ? '0 : rp_r + AW'(1);
      cnt_r <= cnt_r + (AW+1)'(push) - (AW+1)'(pop);
    end
  end

`ifndef SYNTHESIS
  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    push |-> !full) else $error("queue overflow");
  a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> pop_valid) else $error("queue underflow");
  a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= (AW+1)'(DEPTH)) else $error("queue count out of range");
`endif

endmodule

[rtl/adx_back.sv]
`timescale 1ns / 1ps
module adx_back (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          adx_enabled,
  input  logic          q_valid,
  output logic          q_pop,
  input  adx_pkg::dec_t q_data,
  output logic          out_valid,
  input  logic          out_ready,
  output logic [2:0]    out_status,
  output logic [3:0]    out_length,
  output logic          out_wide,
  output logic [3:0]    out_dest_reg,
  output logic [2:0]    out_operand_kind,
  output logic [4:0]    out_base_reg,
  output logic [4:0]    out_index_reg,
  output logic [1:0]    out_scale_shift,
  output logic [31:0]   out_displacement,
  output logic [2:0]    out_disp_bytes,
  output logic [2:0]    out_segment,
  output logic          out_addr32
);

  logic        vld_r;
  logic [2:0]  st_r, st_nxt, kind_r, kind_nxt, db_r, db_nxt, seg_r, seg_nxt;
  logic [3:0]  len_r, len_nxt, dst_r, dst_nxt;
  logic        w_r, w_nxt, a32_r, a32_nxt;
  logic [4:0]  base_r, base_nxt, idx_r, idx_nxt;
  logic [1:0]  sc_r, sc_nxt;
  logic [31:0] disp_r, disp_nxt;
  logic        adx;
  logic [7:0]  m, s;

  assign q_pop = q_valid && (!vld_r || out_ready);
  assign m = q_data.modrm;
  assign s = q_data.sib;
  assign adx = (q_data.status == adx_pkg::ST_ADCX || q_data.status == adx_pkg::ST_ADOX);

  always_comb begin
    st_nxt = q_data.status; len_nxt = q_data.length; w_nxt = 1'b0; dst_nxt = '0;
    kind_nxt = adx_pkg::OK_REG; base_nxt = adx_pkg::NONE_REG; idx_nxt = adx_pkg::NONE_REG;
    sc_nxt = '0; disp_nxt = '0; db_nxt = '0; seg_nxt = '0; a32_nxt = 1'b0;
    if (adx && !adx_enabled) begin
      st_nxt = adx_pkg::ST_ILLEGAL;
    end else if (adx) begin
      w_nxt = q_data.rex[3];
      dst_nxt = {q_data.rex[2], m[5:3]};
      if (m[7:6] == 2'd3) begin
        base_nxt = {1'b0, q_data.rex[0], m[2:0]};
      end else if (m[2:0] != 3'd4) begin
        if (m[7:6] == 2'd0 && m[2:0] == 3'd5)
          kind_nxt = q_data.a32 ? adx_pkg::OK_ABS : adx_pkg::OK_RIP;
        else begin
          kind_nxt = adx_pkg::OK_BASE;
          base_nxt = {1'b0, q_data.rex[0], m[2:0]};
        end
      end else begin
        kind_nxt = adx_pkg::OK_SIB;
        if (!(s[5:3] == 3'd4 && !q_data.rex[1])) idx_nxt = {1'b0, q_data.rex[1], s[5:3]};
        sc_nxt = s[7:6];
        if (!(m[7:6] == 2'd0 && s[2:0] == 3'd5)) base_nxt = {1'b0, q_data.rex[0], s[2:0]};
      end
      db_nxt = q_data.disp_bytes;
      if (db_nxt == 3'd1) disp_nxt = {{24{q_data.disp[7]}}, q_data.disp[7:0]};
      else if (db_nxt == 3'd4) disp_nxt = q_data.disp;
      seg_nxt = q_data.segment;
      a32_nxt = q_data.a32;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) vld_r <= 1'b0;
    else if (q_pop) vld_r <= 1'b1;
    else if (out_ready) vld_r <= 1'b0;
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      st_r <= st_nxt; len_r <= len_nxt; w_r <= w_nxt; dst_r <= dst_nxt;
      kind_r <= kind_nxt; base_r <= base_nxt; idx_r <= idx_nxt; sc_r <= sc_nxt;
      disp_r <= disp_nxt; db_r <= db_nxt; seg_r <= seg_nxt; a32_r <= a32_nxt;
    end
  end

  assign out_valid = vld_r;
  assign out_status = st_r;
  assign out_length = len_r;
  assign out_wide = w_r;
  assign out_dest_reg = dst_r;
  assign out_operand_kind = kind_r;
  assign out_base_reg = base_r;
  assign out_index_reg = idx_r;
  assign out_scale_shift = sc_r;
  assign out_displacement = disp_r;
  assign out_disp_bytes = db_r;
  assign out_segment = seg_r;
  assign out_addr32 = a32_r;

`ifndef SYNTHESIS
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_ready) |=> (out_valid && $stable(out_status)))
    else $error("result changed under stall");
  a_none_regs: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_status != adx_pkg::ST_ADCX && out_status != adx_pkg::ST_ADOX)
    |-> (out_base_reg == adx_pkg::NONE_REG && out_index_reg == adx_pkg::NONE_REG))
    else $error("plain result carries registers");
  a_illegal_gate: assert property (@(posedge clk) disable iff (!rst_n)
    (q_pop && adx && !adx_enabled) |=> out_status == adx_pkg::ST_ILLEGAL)
    else $error("gate ignored");
`endif

endmodule

[rtl/adx_pkru_instruction_decoder_top.sv]
`timescale 1ns / 1ps
// adx/pkru instruction recognizer over a byte stream
// input channel: in_valid/in_ready carries one code byte per transaction,
//   in_window_end marks the last byte of a fetch window
// result channel: out_valid/out_ready, at most one transaction per window,
//   issued at the byte that decides it (or the window end)
// cfg_we/cfg_wdata writes the adx enable bit, taken at once; write only when idle
// throughput: one byte per cycle while the queue is not full; the front decoder
//   updates its phase once per accepted byte
// path: a result passes from its deciding byte into the queue (two entries
//   by default) and then into the back output register
// when the receiver stalls the output register holds, the queue fills, and
//   in_ready falls once the queue is full; bytes that produce no result are
//   still blocked then
// reset (rst_n low, synchronous) clears the window state, the queue and the
//   output valid, and turns adx off
module adx_pkru_instruction_decoder_top #(
  parameter int unsigned QUEUE_DEPTH = adx_pkg::QueueDepth
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic        cfg_wdata,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  in_code_byte,
  input  logic        in_window_end,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [2:0]  out_status,
  output logic [3:0]  out_length,
  output logic        out_wide,
  output logic [3:0]  out_dest_reg,
  output logic [2:0]  out_operand_kind,
  output logic [4:0]  out_base_reg,
  output logic [4:0]  out_index_reg,
  output logic [1:0]  out_scale_shift,
  output logic [31:0] out_displacement,
  output logic [2:0]  out_disp_bytes,
  output logic [2:0]  out_segment,
  output logic        out_addr32
);

  logic          en_r;
  logic          q_push, q_full, q_valid, q_pop;
  adx_pkg::dec_t q_in, q_out;

  always_ff @(posedge clk) begin
    if (!rst_n) en_r <= 1'b0;
    else if (cfg_we) en_r <= cfg_wdata;
  end

  adx_front u_front (
    .clk, .rst_n, .in_valid, .in_ready, .in_code_byte, .in_window_end,
    .q_push, .q_data(q_in), .q_full
  );

  adx_queue #(.DEPTH(QUEUE_DEPTH)) u_queue (
    .clk, .rst_n, .push(q_push), .push_data(q_in), .full(q_full),
    .pop_valid(q_valid), .pop(q_pop), .pop_data(q_out)
  );

  adx_back u_back (
    .clk, .rst_n, .adx_enabled(en_r), .q_valid, .q_pop, .q_data(q_out),
    .out_valid, .out_ready, .out_status, .out_length, .out_wide, .out_dest_reg,
    .out_operand_kind, .out_base_reg, .out_index_reg, .out_scale_shift,
    .out_displacement, .out_disp_bytes, .out_segment, .out_addr32
  );

endmodule
